@@ src/drm_pkg.sv @@
// Shared types, codes and helpers for the duet register machine.
package drm_pkg;

  localparam int REGISTER_COUNT = 26;
  localparam int REG_IDX_W      = 5;
  localparam logic [REG_IDX_W-1:0] REG_P = 5'd15;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic CFG_PROGRAM_LENGTH   = 1'b0;
  localparam logic CFG_PROGRAM_IDENTITY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DELIVER = 2'd1,
    CMD_EXECUTE = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_SND = 3'd0,
    OP_SET = 3'd1,
    OP_ADD = 3'd2,
    OP_MUL = 3'd3,
    OP_MOD = 3'd4,
    OP_RCV = 3'd5,
    OP_JGZ = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SENT    = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_STOPPED = 3'd3,
    ST_MODZERO = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_READ_X,
    B_READ_Y,
    B_EXEC,
    B_ALU,
    B_POP
  } back_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_MOD,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  load_address;
    op_t         opcode;
    logic        x_is_register;
    logic [31:0] x_operand;
    logic        y_is_register;
    logic [31:0] y_operand;
    logic [63:0] message_value;
  } item_t;

  typedef struct packed {
    logic [6:0] program_length;
    logic       program_identity;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic is_mod;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

  function automatic logic reg_in_range(input logic [31:0] idx);
    return idx < 32'(REGISTER_COUNT);
  endfunction

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // live: the register has been written since the last clear
  function automatic logic [63:0] operand_value(input logic        is_reg,
                                                input logic [31:0] raw,
                                                input logic [63:0] rdata,
                                                input logic        live);
    logic [63:0] v;
    if (is_reg) begin
      v = (reg_in_range(raw) && live) ? rdata : 64'd0;
    end else begin
      v = sext32(raw);
    end
    return v;
  endfunction

endpackage

@@ src/duet_register_machine.sv @@
// Top level of the duet register machine: configuration registers and front/back hookup.
//
// Runs one program of the duet assembly scheme. Each input beat loads one
// instruction, delivers one message into the inbox, executes one instruction
// or restarts the machine, and each gives exactly one result beat. Input beats
// land in a two-entry queue, so the front keeps taking beats while the back is
// busy or a result waits on out_ready. The back takes one item at a time: load,
// deliver and restart finish as they leave the queue; an execute spends a
// program memory read and two register file reads (one read port) and then
// finishes, after the shared 32x32 multiplier for mul, the bit-serial
// remainder unit for mod, or an inbox read for a receive. Mod sets the worst
// case per item. Reset and restart clear the register file at once
// through per-register valid bits; program memory and inbox contents are
// undefined until written. Configuration writes take effect on the next cycle
// and are meant for an idle block.
module duet_register_machine #(
  parameter int PROGRAM_DEPTH = 64,
  parameter int INBOX_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [5:0]  load_address,
  input  logic [2:0]  opcode,
  input  logic        x_is_register,
  input  logic [31:0] x_operand,
  input  logic        y_is_register,
  input  logic [31:0] y_operand,
  input  logic [63:0] message_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] sent_value,
  output logic [31:0] program_counter,
  output logic [4:0]  inbox_count,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  drm_pkg::cfg_t  cfg;
  drm_pkg::item_t in_item;
  drm_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      if (cfg_index == drm_pkg::CFG_PROGRAM_LENGTH) begin
        cfg.program_length <= cfg_data;
      end else begin
        cfg.program_identity <= cfg_data[0];
      end
    end
  end

  // classify the incoming beat
  assign in_item.cmd           = drm_pkg::cmd_t'(command);
  assign in_item.load_address  = load_address;
  assign in_item.opcode        = drm_pkg::op_t'(opcode);
  assign in_item.x_is_register = x_is_register;
  assign in_item.x_operand     = x_operand;
  assign in_item.y_is_register = y_is_register;
  assign in_item.y_operand     = y_operand;
  assign in_item.message_value = message_value;

  drm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  drm_back #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .INBOX_DEPTH  (INBOX_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .sent_value     (sent_value),
    .program_counter(program_counter),
    .inbox_count    (inbox_count)
  );

endmodule

@@ src/drm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module drm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/drm_front.sv @@
// Front end: takes input beats and queues them for the back end.
module drm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  drm_pkg::item_t in_item,
  output logic           q_valid,
  output drm_pkg::item_t q_item,
  input  logic           q_pop
);

  localparam int QW = $clog2(drm_pkg::QUEUE_DEPTH + 1);

  drm_pkg::item_t slot [drm_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [QW-1:0]  count;
  logic           push;

  assign in_ready = count != QW'(drm_pkg::QUEUE_DEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + QW'(1);
      end else if (!push && q_pop) begin
        count <= count - QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

endmodule

@@ src/drm_alu.sv @@
// Multi-cycle multiply (three 32x32 partial products) and truncated remainder.
module drm_alu (
  input  logic              clk,
  input  logic              rst,
  input  drm_pkg::alu_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output drm_pkg::alu_rsp_t rsp,
  output logic [63:0]       result
);

  drm_pkg::alu_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic [63:0] opa, opa_next, opb, opb_next;
  logic [63:0] acc, acc_next, prod, prod_next;
  logic [63:0] rem, rem_next, dvd, dvd_next, mb, mb_next;
  logic        neg, neg_next, is_mod, is_mod_next;
  logic [31:0] mul_a, mul_b;
  logic [63:0] rem_sh;

  always_comb begin
    state_next = state;
    unique case (state)
      drm_pkg::A_IDLE: begin
        if (req.start) begin
          state_next = req.is_mod ? drm_pkg::A_MOD : drm_pkg::A_MUL;
        end
      end
      drm_pkg::A_MUL: begin
        if (cnt == 6'd3) begin
          state_next = drm_pkg::A_DONE;
        end
      end
      drm_pkg::A_MOD: begin
        if (cnt == 6'd63) begin
          state_next = drm_pkg::A_DONE;
        end
      end
      drm_pkg::A_DONE: state_next = drm_pkg::A_IDLE;
      default:         state_next = drm_pkg::A_IDLE;
    endcase
  end

  // partial product order: lo*lo, lo*hi, hi*lo; hi*hi falls off the top
  assign mul_a  = (cnt == 6'd2) ? opa[63:32] : opa[31:0];
  assign mul_b  = (cnt == 6'd1) ? opb[63:32] : opb[31:0];
  assign rem_sh = {rem[62:0], dvd[63]};

  always_comb begin
    cnt_next    = cnt;
    opa_next    = opa;
    opb_next    = opb;
    acc_next    = acc;
    prod_next   = prod;
    rem_next    = rem;
    dvd_next    = dvd;
    mb_next     = mb;
    neg_next    = neg;
    is_mod_next = is_mod;
    rsp.done    = 1'b0;
    unique case (state)
      drm_pkg::A_IDLE: begin
        if (req.start) begin
          cnt_next    = '0;
          opa_next    = a;
          opb_next    = b;
          acc_next    = '0;
          rem_next    = '0;
          dvd_next    = a[63] ? 64'd0 - a : a;
          mb_next     = b[63] ? 64'd0 - b : b;
          neg_next    = a[63];
          is_mod_next = req.is_mod;
        end
      end
      drm_pkg::A_MUL: begin
        prod_next = {32'd0, mul_a} * {32'd0, mul_b};
        if (cnt == 6'd1) begin
          acc_next = prod;
        end else if (cnt != 6'd0) begin
          acc_next = acc + {prod[31:0], 32'd0};
        end
        cnt_next = cnt + 6'd1;
      end
      drm_pkg::A_MOD: begin
        rem_next = (rem_sh >= mb) ? rem_sh - mb : rem_sh;
        dvd_next = {dvd[62:0], 1'b0};
        cnt_next = cnt + 6'd1;
      end
      drm_pkg::A_DONE: rsp.done = 1'b1;
      default: ;
    endcase
  end

  assign result = is_mod ? (neg ? 64'd0 - rem : rem) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drm_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    opa    <= opa_next;
    opb    <= opb_next;
    acc    <= acc_next;
    prod   <= prod_next;
    rem    <= rem_next;
    dvd    <= dvd_next;
    mb     <= mb_next;
    neg    <= neg_next;
    is_mod <= is_mod_next;
  end

endmodule

@@ src/drm_back.sv @@
// Back end: program memory, register file, inbox and the execute sequencer.
module drm_back #(
  parameter int PROGRAM_DEPTH = 64,
  parameter int INBOX_DEPTH   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  drm_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  drm_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     status,
  output logic [63:0]    sent_value,
  output logic [31:0]    program_counter,
  output logic [4:0]     inbox_count
);

  localparam int PA = PROGRAM_DEPTH > 1 ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int IW = INBOX_DEPTH > 1 ? $clog2(INBOX_DEPTH) : 1;
  localparam int FW = $clog2(INBOX_DEPTH + 1);
  localparam int SW = IW + FW;
  localparam int RW = drm_pkg::REG_IDX_W;
  localparam int RC = drm_pkg::REGISTER_COUNT;

  drm_pkg::back_state_t state, state_next;
  logic [31:0]       counter, counter_next;
  logic [IW-1:0]     head, head_next;
  logic [FW-1:0]     fill, fill_next;
  logic [RC-1:0]     valid_bits, valid_next;
  drm_pkg::op_t      op, op_next;
  logic              xr, xr_next, yr, yr_next;
  logic [31:0]       xraw, xraw_next, yraw, yraw_next;
  logic [63:0]       xv, xv_next, yv, yv_next;
  logic              out_valid_next;
  drm_pkg::status_t  out_status, out_status_next;
  logic [63:0]       out_sent, out_sent_next;
  logic [31:0]       out_pc, out_pc_next;
  logic [4:0]        out_count, out_count_next;

  logic              start, run_ok, finish, load_ok, dest_ok;
  logic [31:0]       limit;
  drm_pkg::status_t  res_status;
  logic [63:0]       res_sent;
  logic [PA+5:0]     load_ext;
  logic [SW-1:0]     wsum, hinc;
  logic [FW+4:0]     fill_ext;
  logic [31:0]       vpad;

  logic              pa_we, pb_we;
  logic [35:0]       pa_rdata;
  logic [32:0]       pb_rdata;
  logic [PA-1:0]     prog_waddr;
  logic              reg_we;
  logic [RW-1:0]     reg_waddr, reg_raddr;
  logic [63:0]       reg_wdata, reg_rdata;
  logic              ib_we;
  logic [63:0]       ib_rdata;
  drm_pkg::alu_req_t alu_req;
  drm_pkg::alu_rsp_t alu_rsp;
  logic [63:0]       alu_result;

  assign start   = (state == drm_pkg::B_IDLE) && q_valid && (!out_valid || out_ready);
  assign q_pop   = start;
  assign limit   = (32'(cfg.program_length) < 32'(PROGRAM_DEPTH)) ?
                   32'(cfg.program_length) : 32'(PROGRAM_DEPTH);
  assign run_ok  = counter < limit;
  assign load_ok = 32'(q_item.load_address) < 32'(PROGRAM_DEPTH);
  assign load_ext   = {{PA{1'b0}}, q_item.load_address};
  assign prog_waddr = load_ext[PA-1:0];
  assign dest_ok = xr && drm_pkg::reg_in_range(xraw);
  assign vpad    = {{(32 - RC){1'b0}}, valid_bits};

  always_comb begin
    wsum = SW'(head) + SW'(fill);
    if (wsum >= SW'(INBOX_DEPTH)) begin
      wsum = wsum - SW'(INBOX_DEPTH);
    end
    hinc = SW'(head) + SW'(1);
    if (hinc == SW'(INBOX_DEPTH)) begin
      hinc = '0;
    end
  end

  drm_ram #(.WIDTH(36), .DEPTH(PROGRAM_DEPTH)) u_prog_a (
    .clk  (clk),
    .we   (pa_we),
    .waddr(prog_waddr),
    .wdata({q_item.opcode, q_item.x_is_register, q_item.x_operand}),
    .raddr(counter[PA-1:0]),
    .rdata(pa_rdata)
  );

  drm_ram #(.WIDTH(33), .DEPTH(PROGRAM_DEPTH)) u_prog_b (
    .clk  (clk),
    .we   (pb_we),
    .waddr(prog_waddr),
    .wdata({q_item.y_is_register, q_item.y_operand}),
    .raddr(counter[PA-1:0]),
    .rdata(pb_rdata)
  );

  drm_ram #(.WIDTH(64), .DEPTH(RC)) u_regs (
    .clk  (clk),
    .we   (reg_we),
    .waddr(reg_waddr),
    .wdata(reg_wdata),
    .raddr(reg_raddr),
    .rdata(reg_rdata)
  );

  drm_ram #(.WIDTH(64), .DEPTH(INBOX_DEPTH)) u_inbox (
    .clk  (clk),
    .we   (ib_we),
    .waddr(wsum[IW-1:0]),
    .wdata(q_item.message_value),
    .raddr(head),
    .rdata(ib_rdata)
  );

  drm_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .a     (xv),
    .b     (yv),
    .rsp   (alu_rsp),
    .result(alu_result)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      drm_pkg::B_IDLE: begin
        if (start && q_item.cmd == drm_pkg::CMD_EXECUTE && run_ok) begin
          state_next = drm_pkg::B_FETCH;
        end
      end
      drm_pkg::B_FETCH:  state_next = drm_pkg::B_READ_X;
      drm_pkg::B_READ_X: state_next = drm_pkg::B_READ_Y;
      drm_pkg::B_READ_Y: state_next = drm_pkg::B_EXEC;
      drm_pkg::B_EXEC: begin
        unique case (op)
          drm_pkg::OP_MUL: state_next = drm_pkg::B_ALU;
          drm_pkg::OP_MOD: state_next = (yv == 64'd0) ? drm_pkg::B_IDLE : drm_pkg::B_ALU;
          drm_pkg::OP_RCV: state_next = (fill == '0) ? drm_pkg::B_IDLE : drm_pkg::B_POP;
          drm_pkg::OP_SND, drm_pkg::OP_SET, drm_pkg::OP_ADD,
          drm_pkg::OP_JGZ, drm_pkg::OP_NOP: state_next = drm_pkg::B_IDLE;
        endcase
      end
      drm_pkg::B_ALU: begin
        if (alu_rsp.done) begin
          state_next = drm_pkg::B_IDLE;
        end
      end
      drm_pkg::B_POP: state_next = drm_pkg::B_IDLE;
      default:        state_next = drm_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    counter_next   = counter;
    head_next      = head;
    fill_next      = fill;
    valid_next     = valid_bits;
    op_next        = op;
    xr_next        = xr;
    xraw_next      = xraw;
    yr_next        = yr;
    yraw_next      = yraw;
    xv_next        = xv;
    yv_next        = yv;
    pa_we          = 1'b0;
    pb_we          = 1'b0;
    reg_we         = 1'b0;
    reg_waddr      = xraw[RW-1:0];
    reg_wdata      = 64'd0;
    reg_raddr      = yraw[RW-1:0];
    ib_we          = 1'b0;
    alu_req.start  = 1'b0;
    alu_req.is_mod = (op == drm_pkg::OP_MOD);
    finish         = 1'b0;
    res_status     = drm_pkg::ST_OK;
    res_sent       = 64'd0;
    unique case (state)
      drm_pkg::B_IDLE: begin
        if (start) begin
          unique case (q_item.cmd)
            drm_pkg::CMD_LOAD: begin
              pa_we  = load_ok;
              pb_we  = load_ok;
              finish = 1'b1;
            end
            drm_pkg::CMD_DELIVER: begin
              finish = 1'b1;
              if (32'(fill) >= 32'(INBOX_DEPTH)) begin
                res_status = drm_pkg::ST_FULL;
              end else begin
                ib_we     = 1'b1;
                fill_next = fill + FW'(1);
              end
            end
            drm_pkg::CMD_EXECUTE: begin
              if (!run_ok) begin
                finish     = 1'b1;
                res_status = drm_pkg::ST_STOPPED;
              end
            end
            drm_pkg::CMD_RESTART: begin
              finish       = 1'b1;
              counter_next = 32'd0;
              valid_next   = RC'(1) << drm_pkg::REG_P;
              reg_we       = 1'b1;
              reg_waddr    = drm_pkg::REG_P;
              reg_wdata    = {63'd0, cfg.program_identity};
            end
          endcase
        end
      end
      drm_pkg::B_FETCH: begin
        op_next   = drm_pkg::op_t'(pa_rdata[35:33]);
        xr_next   = pa_rdata[32];
        xraw_next = pa_rdata[31:0];
        yr_next   = pb_rdata[32];
        yraw_next = pb_rdata[31:0];
        reg_raddr = pa_rdata[RW-1:0];
      end
      drm_pkg::B_READ_X: begin
        xv_next   = drm_pkg::operand_value(xr, xraw, reg_rdata, vpad[xraw[RW-1:0]]);
        reg_raddr = yraw[RW-1:0];
      end
      drm_pkg::B_READ_Y: begin
        yv_next = drm_pkg::operand_value(yr, yraw, reg_rdata, vpad[yraw[RW-1:0]]);
      end
      drm_pkg::B_EXEC: begin
        unique case (op)
          drm_pkg::OP_SND: begin
            finish       = 1'b1;
            res_status   = drm_pkg::ST_SENT;
            res_sent     = xv;
            counter_next = counter + 32'd1;
          end
          drm_pkg::OP_SET, drm_pkg::OP_ADD: begin
            finish       = 1'b1;
            reg_we       = dest_ok;
            reg_wdata    = (op == drm_pkg::OP_SET) ? yv : xv + yv;
            counter_next = counter + 32'd1;
          end
          drm_pkg::OP_MUL: alu_req.start = 1'b1;
          drm_pkg::OP_MOD: begin
            if (yv == 64'd0) begin
              finish     = 1'b1;
              res_status = drm_pkg::ST_MODZERO;
            end else begin
              alu_req.start = 1'b1;
            end
          end
          drm_pkg::OP_RCV: begin
            if (fill == '0) begin
              finish     = 1'b1;
              res_status = drm_pkg::ST_BLOCKED;
            end
          end
          drm_pkg::OP_JGZ: begin
            finish       = 1'b1;
            counter_next = ($signed(xv) > 64'sd0) ? counter + yv[31:0] : counter + 32'd1;
          end
          drm_pkg::OP_NOP: begin
            finish       = 1'b1;
            counter_next = counter + 32'd1;
          end
        endcase
      end
      drm_pkg::B_ALU: begin
        if (alu_rsp.done) begin
          finish       = 1'b1;
          reg_we       = dest_ok;
          reg_wdata    = alu_result;
          counter_next = counter + 32'd1;
        end
      end
      drm_pkg::B_POP: begin
        finish       = 1'b1;
        reg_we       = dest_ok;
        reg_wdata    = ib_rdata;
        head_next    = hinc[IW-1:0];
        fill_next    = fill - FW'(1);
        counter_next = counter + 32'd1;
      end
      default: ;
    endcase

    if (reg_we && state != drm_pkg::B_IDLE) begin
      valid_next = valid_bits | (RC'(1) << reg_waddr);
    end

    fill_ext        = {5'd0, fill_next};
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_sent_next   = out_sent;
    out_pc_next     = out_pc;
    out_count_next  = out_count;
    if (finish) begin
      out_valid_next  = 1'b1;
      out_status_next = res_status;
      out_sent_next   = res_sent;
      out_pc_next     = counter_next;
      out_count_next  = fill_ext[4:0];
    end
  end

  assign status          = out_status;
  assign sent_value      = out_sent;
  assign program_counter = out_pc;
  assign inbox_count     = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= drm_pkg::B_IDLE;
      counter    <= 32'd0;
      head       <= '0;
      fill       <= '0;
      valid_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      counter    <= counter_next;
      head       <= head_next;
      fill       <= fill_next;
      valid_bits <= valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    xr         <= xr_next;
    xraw       <= xraw_next;
    yr         <= yr_next;
    yraw       <= yraw_next;
    xv         <= xv_next;
    yv         <= yv_next;
    out_status <= out_status_next;
    out_sent   <= out_sent_next;
    out_pc     <= out_pc_next;
    out_count  <= out_count_next;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(INBOX_DEPTH))
    else $error("inbox fill beyond depth");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    state == drm_pkg::B_POP |=> out_valid)
    else $error("receive did not produce a result");

  a_alu_handoff: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |=> state == drm_pkg::B_ALU && !alu_rsp.done)
    else $error("alu start without wait state");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    start && q_item.cmd == drm_pkg::CMD_RESTART
    |=> counter == 32'd0 && valid_bits == (RC'(1) << drm_pkg::REG_P))
    else $error("restart did not clear machine state");

endmodule

@@ dv/duet_register_machine_tb.sv @@
// Self-checking testbench for the duet register machine.
module duet_register_machine_tb;

  localparam int PROG_SLOTS = 64;
  localparam int INBOX_CAP  = 16;
  localparam int DRAIN_WAIT = 80;   // covers the worst execute (mod)

  typedef struct {
    drm_pkg::status_t status;
    logic [63:0]      sent;
    logic [31:0]      pc;
    logic [4:0]       count;
  } result_t;

  // Shadow machine: holds program, registers, counter and inbox, and the
  // results still owed by the block in beat order.
  class machine_scoreboard;
    drm_pkg::op_t slot_op [PROG_SLOTS];
    logic         slot_xr [PROG_SLOTS];
    logic [31:0]  slot_x  [PROG_SLOTS];
    logic         slot_yr [PROG_SLOTS];
    logic [31:0]  slot_y  [PROG_SLOTS];
    bit           slot_loaded [PROG_SLOTS];
    logic [63:0]  regs [drm_pkg::REGISTER_COUNT];
    logic [31:0]  pc;
    logic [63:0]  inbox [$];
    logic [6:0]   prog_len;
    logic         prog_id;
    result_t      owed [$];
    int           errors;

    function new();
      foreach (slot_loaded[i]) slot_loaded[i] = 0;
      foreach (regs[i]) regs[i] = '0;
      pc = '0; prog_len = '0; prog_id = 1'b0; errors = 0;
    endfunction

    function logic [31:0] limit();
      return (prog_len < PROG_SLOTS) ? 32'(prog_len) : 32'(PROG_SLOTS);
    endfunction

    // True when an execute now would fetch a slot that was never loaded.
    function bit needs_load();
      return (pc < limit()) && !slot_loaded[pc];
    endfunction

    function logic [63:0] fetch_operand(logic is_reg, logic [31:0] raw);
      if (is_reg) return (raw < drm_pkg::REGISTER_COUNT) ? regs[raw] : 64'd0;
      return {{32{raw[31]}}, raw};
    endfunction

    function void write_reg(logic is_reg, logic [31:0] raw, logic [63:0] v);
      if (is_reg && raw < drm_pkg::REGISTER_COUNT) regs[raw] = v;
    endfunction

    function drm_pkg::status_t step_program(output logic [63:0] sent);
      logic [63:0] xv, yv, ma, mb, rem;
      int s;
      sent = '0;
      if (pc >= limit()) return drm_pkg::ST_STOPPED;
      s  = pc;
      xv = fetch_operand(slot_xr[s], slot_x[s]);
      yv = fetch_operand(slot_yr[s], slot_y[s]);
      case (slot_op[s])
        drm_pkg::OP_SND: begin
          sent = xv;
          pc++;
          return drm_pkg::ST_SENT;
        end
        drm_pkg::OP_SET: write_reg(slot_xr[s], slot_x[s], yv);
        drm_pkg::OP_ADD: write_reg(slot_xr[s], slot_x[s], xv + yv);
        drm_pkg::OP_MUL: write_reg(slot_xr[s], slot_x[s], xv * yv);
        drm_pkg::OP_MOD: begin
          if (yv == 0) return drm_pkg::ST_MODZERO;
          // truncated remainder, sign of dividend; min mod -1 falls out as 0
          ma  = xv[63] ? -xv : xv;
          mb  = yv[63] ? -yv : yv;
          rem = ma % mb;
          write_reg(slot_xr[s], slot_x[s], xv[63] ? -rem : rem);
        end
        drm_pkg::OP_RCV: begin
          if (inbox.size() == 0) return drm_pkg::ST_BLOCKED;
          write_reg(slot_xr[s], slot_x[s], inbox.pop_front());
        end
        drm_pkg::OP_JGZ: begin
          if (xv != 0 && !xv[63]) begin
            pc += yv[31:0];
            return drm_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      pc++;
      return drm_pkg::ST_OK;
    endfunction

    function void note_item(drm_pkg::item_t it);
      result_t r;
      r.status = drm_pkg::ST_OK;
      r.sent   = '0;
      case (it.cmd)
        drm_pkg::CMD_LOAD: begin
          slot_op[it.load_address]     = it.opcode;
          slot_xr[it.load_address]     = it.x_is_register;
          slot_x[it.load_address]      = it.x_operand;
          slot_yr[it.load_address]     = it.y_is_register;
          slot_y[it.load_address]      = it.y_operand;
          slot_loaded[it.load_address] = 1;
        end
        drm_pkg::CMD_DELIVER: begin
          if (inbox.size() >= INBOX_CAP) r.status = drm_pkg::ST_FULL;
          else inbox.insert(inbox.size(), it.message_value);
        end
        drm_pkg::CMD_EXECUTE: r.status = step_program(r.sent);
        default: begin
          foreach (regs[i]) regs[i] = '0;
          regs[drm_pkg::REG_P] = 64'(prog_id);
          pc = '0;
        end
      endcase
      r.pc    = pc;
      r.count = 5'(inbox.size());
      owed.insert(owed.size(), r);
    endfunction

    function void check_result(result_t act);
      result_t e;
      if (owed.size() == 0) begin
        $display("%0t: result beat with nothing owed (status %0d)", $time, act.status);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (e.status != act.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, act.status);
        errors++;
      end
      if (e.sent != act.sent) begin
        $display("%0t: sent_value exp %h got %h", $time, e.sent, act.sent);
        errors++;
      end
      if (e.pc != act.pc) begin
        $display("%0t: program_counter exp %h got %h", $time, e.pc, act.pc);
        errors++;
      end
      if (e.count != act.count) begin
        $display("%0t: inbox_count exp %0d got %0d", $time, e.count, act.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  command;
  logic [5:0]  load_address;
  logic [2:0]  opcode;
  logic        x_is_register, y_is_register;
  logic [31:0] x_operand, y_operand;
  logic [63:0] message_value;
  logic [2:0]  status;
  logic [63:0] sent_value;
  logic [31:0] program_counter;
  logic [4:0]  inbox_count;
  logic        cfg_write;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  duet_register_machine u_dut (.*);

  machine_scoreboard sb = new();
  int beats_sent = 0;
  int burst_left = 0;
  int stall_cyc  = 0;
  int stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: fails a run that does not finish in time.
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  // Result side: stall pattern is picked anew at regular intervals among always
  // ready, random stalls and a fixed duty cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((stall_cyc % 7) < 3);
      endcase
    end
  end

  // Monitor sees pre-edge values, so acceptance is exactly the handshake.
  always @(posedge clk) begin
    result_t act;
    if (!rst && out_valid && out_ready) begin
      act.status = drm_pkg::status_t'(status);
      act.sent   = sent_value;
      act.pc     = program_counter;
      act.count  = inbox_count;
      sb.check_result(act);
    end
  end

  // Hold one beat until accepted, then maybe open a gap before the next.
  task automatic send_beat(input drm_pkg::item_t it);
    in_valid      <= 1'b1;
    command       <= it.cmd;
    load_address  <= it.load_address;
    opcode        <= it.opcode;
    x_is_register <= it.x_is_register;
    x_operand     <= it.x_operand;
    y_is_register <= it.y_is_register;
    y_operand     <= it.y_operand;
    message_value <= it.message_value;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    beats_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Sender pauses until every owed result is back, then lets the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Only called when idle. Writes both registers on consecutive edges.
  task automatic set_config(input logic [6:0] len, input logic id);
    cfg_write <= 1'b1;
    cfg_index <= drm_pkg::CFG_PROGRAM_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= drm_pkg::CFG_PROGRAM_IDENTITY;
    cfg_data  <= 7'(id);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    sb.prog_len = len;
    sb.prog_id  = id;
  endtask

  function automatic drm_pkg::item_t noise_item(drm_pkg::cmd_t c);
    drm_pkg::item_t it;
    it.cmd           = c;
    it.load_address  = 6'($urandom);
    it.opcode        = drm_pkg::op_t'($urandom_range(0, 7));
    it.x_is_register = 1'($urandom);
    it.x_operand     = $urandom;
    it.y_is_register = 1'($urandom);
    it.y_operand     = $urandom;
    it.message_value = {$urandom, $urandom};
    return it;
  endfunction

  function automatic drm_pkg::item_t instr(logic [5:0] slot, drm_pkg::op_t op, logic xr,
                                           logic [31:0] x, logic yr, logic [31:0] y);
    drm_pkg::item_t it = noise_item(drm_pkg::CMD_LOAD);
    it.load_address  = slot;
    it.opcode        = op;
    it.x_is_register = xr;
    it.x_operand     = x;
    it.y_is_register = yr;
    it.y_operand     = y;
    return it;
  endfunction

  // Operand mostly a live register (a..d or p), sometimes any index or any immediate.
  function automatic logic [31:0] rand_operand(logic is_reg, bit is_jump);
    int k = $urandom_range(0, 9);
    if (is_reg) begin
      if (k < 5) return $urandom_range(0, 3);
      if (k < 6) return 32'(drm_pkg::REG_P);
      if (k < 9) return $urandom_range(0, drm_pkg::REGISTER_COUNT - 1);
      return $urandom;
    end
    if (is_jump) return (k < 9) ? 32'($signed($urandom_range(0, 8)) - 4) : $urandom;
    return (k < 6) ? 32'($signed($urandom_range(0, 10)) - 5) : $urandom;
  endfunction

  function automatic drm_pkg::item_t rand_instr(logic [5:0] slot);
    drm_pkg::op_t op = drm_pkg::op_t'($urandom_range(0, 7));
    logic xr = ($urandom_range(0, 9) < 8);
    logic yr = ($urandom_range(0, 9) < 5);
    return instr(slot, op, xr, rand_operand(xr, 0), yr,
                 rand_operand(yr, op == drm_pkg::OP_JGZ));
  endfunction

  // Execute mostly; an execute that would hit an unloaded slot loads it first.
  function automatic drm_pkg::item_t rand_beat();
    int k = $urandom_range(0, 99);
    if (k < 70) begin
      if (sb.needs_load()) return rand_instr(6'(sb.pc));
      return noise_item(drm_pkg::CMD_EXECUTE);
    end
    if (k < 85) return noise_item(drm_pkg::CMD_DELIVER);
    if (k < 95) return rand_instr(6'($urandom));
    return noise_item(drm_pkg::CMD_RESTART);
  endfunction

  initial begin
    logic [6:0] len;
    int         n;
    rst           = 1'b1;
    in_valid      = 1'b0;
    command       = drm_pkg::CMD_LOAD;
    load_address  = '0;
    opcode        = drm_pkg::OP_SND;
    x_is_register = 1'b0;
    x_operand     = '0;
    y_is_register = 1'b0;
    y_operand     = '0;
    message_value = '0;
    cfg_write     = 1'b0;
    cfg_index     = drm_pkg::CFG_PROGRAM_LENGTH;
    cfg_data      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty program stops, then a short program walking the corners.
    set_config(7'd0, 1'b1);
    send_beat(noise_item(drm_pkg::CMD_EXECUTE));
    send_beat(instr(6'd0, drm_pkg::OP_RCV, 1'b1, 32'd0, 1'b0, 32'd0));
    send_beat(instr(6'd1, drm_pkg::OP_MOD, 1'b1, 32'd0, 1'b0, 32'hFFFF_FFFF));
    send_beat(instr(6'd2, drm_pkg::OP_SET, 1'b1, 32'd1, 1'b0, 32'h8000_0000));
    send_beat(instr(6'd3, drm_pkg::OP_MUL, 1'b1, 32'd1, 1'b1, 32'd1));
    send_beat(instr(6'd4, drm_pkg::OP_ADD, 1'b1, 32'd1, 1'b0, 32'h7FFF_FFFF));
    send_beat(instr(6'd5, drm_pkg::OP_MOD, 1'b1, 32'd1, 1'b1, 32'd2));
    send_beat(instr(6'd6, drm_pkg::OP_SND, 1'b1, 32'd1, 1'b0, 32'd0));
    send_beat(instr(6'd7, drm_pkg::OP_JGZ, 1'b1, 32'(drm_pkg::REG_P), 1'b0,
                    32'hFFFF_FFF9));
    send_beat(instr(6'd63, drm_pkg::OP_SND, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    drain();
    set_config(7'd64, 1'b1);
    send_beat(noise_item(drm_pkg::CMD_RESTART));
    send_beat(noise_item(drm_pkg::CMD_EXECUTE));        // receive on empty inbox blocks
    begin
      drm_pkg::item_t d = noise_item(drm_pkg::CMD_DELIVER);
      d.message_value = 64'h8000_0000_0000_0000;
      send_beat(d);
    end
    repeat (3) send_beat(noise_item(drm_pkg::CMD_EXECUTE));   // rcv, min mod -1, set
    send_beat(noise_item(drm_pkg::CMD_EXECUTE));              // mul squares a negative value
    send_beat(noise_item(drm_pkg::CMD_EXECUTE));              // add
    send_beat(noise_item(drm_pkg::CMD_EXECUTE));              // mod by zero, counter holds
    send_beat(instr(6'd5, drm_pkg::OP_NOP, 1'b1, 32'd1, 1'b1, 32'd2));
    repeat (4) send_beat(noise_item(drm_pkg::CMD_EXECUTE));   // nop, snd, jump back, rcv
    send_beat(noise_item(drm_pkg::CMD_EXECUTE));              // receive blocks again
    drain();

    // Random phases: new setting, fresh program, restart, then a mixed run.
    while (beats_sent < 900) begin
      n = $urandom_range(0, 9);
      len = (n == 0) ? 7'd0 : (n == 1) ? 7'd64 : 7'($urandom_range(1, 12));
      set_config(len, 1'($urandom));
      for (int s = 0; s < ((len < 64) ? len : 64); s++) send_beat(rand_instr(6'(s)));
      send_beat(noise_item(drm_pkg::CMD_RESTART));
      if ($urandom_range(0, 3) == 0) begin
        repeat (18) send_beat(noise_item(drm_pkg::CMD_DELIVER));  // overflow the inbox
      end
      repeat ($urandom_range(30, 80)) send_beat(rand_beat());
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
